FILE: hdl/rbps_pkg.sv
// ---------------------------------------------------------------------------
// rbps_pkg
// Shared types, widths and constants of the rational Bezier path sampler.
// ---------------------------------------------------------------------------
package rbps_pkg;

    localparam int ORDER_W  = 3;
    localparam int COORD_W  = 32;
    localparam int WEIGHT_W = 24;
    localparam int CNT_W    = 7;
    localparam int IDX_W    = 6;

    localparam int DEF_MAX_SAMPLES = 64;
    localparam int DEF_MAX_ORDER   = 4;
    localparam logic [CNT_W-1:0] SAMPLE_COUNT_RESET = 7'd10;

    // Internal widths, sized for an order of at most four and 64 samples.
    localparam int A_W    = 6;   // a = N - k
    localparam int PW     = 19;  // a^(n-1), k^(n-1)
    localparam int CW     = 25;  // a^n, k^n, a^(n-1)*k
    localparam int TW     = 27;  // n*a^(n-1)*k
    localparam int C1W    = 50;  // middle coefficient including the weight
    localparam int DEN_W  = 52;
    localparam int MUL_W  = CW + 1 + COORD_W;
    localparam int ACC_W  = 84;
    localparam int MAG_W  = 83;
    localparam int QN     = 33;  // quotient bits produced by the divider
    localparam int REM_W  = 52;
    localparam int STEP_W = 6;
    localparam int ONE_SHIFT = 16;  // 1.0 in Q16
    localparam int MAC_STEPS = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_POW,
        ST_COEF1,
        ST_COEF2,
        ST_COEF3,
        ST_MAC,
        ST_DIVINIT,
        ST_DIV,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SETUP,
        OP_POW,
        OP_COEF1,
        OP_COEF2,
        OP_COEF3,
        OP_MAC,
        OP_DIVINIT,
        OP_DIV,
        OP_FINISH,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic pow_done;
        logic mac_done;
        logic div_done;
        logic last_k;
        logic out_free;
    } sts_t;

endpackage

FILE: hdl/rbps_in_if.sv
// ---------------------------------------------------------------------------
// rbps_in_if
// Request channel: one path request per item.
// ---------------------------------------------------------------------------
interface rbps_in_if;
    import rbps_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ORDER_W-1:0]         curve_order;
    logic signed [COORD_W-1:0]  start_x;
    logic signed [COORD_W-1:0]  start_y;
    logic signed [COORD_W-1:0]  ref_x;
    logic signed [COORD_W-1:0]  ref_y;
    logic [WEIGHT_W-1:0]        ref_weight;
    logic signed [COORD_W-1:0]  end_x;
    logic signed [COORD_W-1:0]  end_y;

    modport source (output valid, curve_order, start_x, start_y, ref_x, ref_y,
                    ref_weight, end_x, end_y, input ready);
    modport sink (input valid, curve_order, start_x, start_y, ref_x, ref_y,
                  ref_weight, end_x, end_y, output ready);
endinterface

FILE: hdl/rbps_out_if.sv
// ---------------------------------------------------------------------------
// rbps_out_if
// Sample channel: one curve point per item.
// ---------------------------------------------------------------------------
interface rbps_out_if;
    import rbps_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [IDX_W-1:0]           sample_index;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic                       div_error;
    logic                       last_sample;

    modport source (output valid, sample_index, point_x, point_y, div_error,
                    last_sample, input ready);
    modport sink (input valid, sample_index, point_x, point_y, div_error,
                  last_sample, output ready);
endinterface

FILE: hdl/rbps_ctrl.sv
// ---------------------------------------------------------------------------
// rbps_ctrl
// Sequencer that steps the datapath through one sample after another.
// ---------------------------------------------------------------------------
module rbps_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rbps_pkg::sts_t sts,
    output rbps_pkg::cmd_t cmd
);
    import rbps_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_SETUP;
            ST_SETUP:   state_next = ST_POW;
            ST_POW:     if (sts.pow_done) state_next = ST_COEF1;
            ST_COEF1:   state_next = ST_COEF2;
            ST_COEF2:   state_next = ST_COEF3;
            ST_COEF3:   state_next = ST_MAC;
            ST_MAC:     if (sts.mac_done) state_next = ST_DIVINIT;
            ST_DIVINIT: state_next = ST_DIV;
            ST_DIV:     if (sts.div_done) state_next = ST_FINISH;
            ST_FINISH:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.last_k ? ST_IDLE : ST_SETUP;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd.op = OP_LOAD;
            end
            ST_SETUP:   cmd.op = OP_SETUP;
            ST_POW:     if (!sts.pow_done) cmd.op = OP_POW;
            ST_COEF1:   cmd.op = OP_COEF1;
            ST_COEF2:   cmd.op = OP_COEF2;
            ST_COEF3:   cmd.op = OP_COEF3;
            ST_MAC:     cmd.op = OP_MAC;
            ST_DIVINIT: cmd.op = OP_DIVINIT;
            ST_DIV:     cmd.op = OP_DIV;
            ST_FINISH:  cmd.op = OP_FINISH;
            ST_OUT:     if (sts.out_free) cmd.op = OP_EMIT;
            default:    cmd.op = OP_NONE;
        endcase
    end

endmodule

FILE: hdl/rbps_dp.sv
// ---------------------------------------------------------------------------
// rbps_dp
// Datapath: Bernstein coefficients, one shared multiply-accumulate unit,
// two restoring dividers and the output register.
// ---------------------------------------------------------------------------
module rbps_dp #(
    parameter int MAX_SAMPLES = rbps_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_ORDER   = rbps_pkg::DEF_MAX_ORDER
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rbps_pkg::cmd_t                     cmd,
    output rbps_pkg::sts_t                     sts,
    input  logic                               cfg_wr_en,
    input  logic [rbps_pkg::CNT_W-1:0]         cfg_wr_data,
    input  logic [rbps_pkg::ORDER_W-1:0]       in_order,
    input  logic signed [rbps_pkg::COORD_W-1:0] in_sx,
    input  logic signed [rbps_pkg::COORD_W-1:0] in_sy,
    input  logic signed [rbps_pkg::COORD_W-1:0] in_rx,
    input  logic signed [rbps_pkg::COORD_W-1:0] in_ry,
    input  logic [rbps_pkg::WEIGHT_W-1:0]      in_w,
    input  logic signed [rbps_pkg::COORD_W-1:0] in_ex,
    input  logic signed [rbps_pkg::COORD_W-1:0] in_ey,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rbps_pkg::IDX_W-1:0]         out_index,
    output logic signed [rbps_pkg::COORD_W-1:0] out_x,
    output logic signed [rbps_pkg::COORD_W-1:0] out_y,
    output logic                               out_err,
    output logic                               out_last
);
    import rbps_pkg::*;

    localparam logic [ORDER_W-1:0] MAX_ORD = ORDER_W'(MAX_ORDER);
    localparam logic [CNT_W-1:0]   MAX_CNT = CNT_W'(MAX_SAMPLES);
    localparam logic [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] NEG_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    logic [CNT_W-1:0]          sc_reg;
    logic [ORDER_W-1:0]        ord_reg;
    logic [COORD_W-1:0]        p0x_reg, p0y_reg, p1x_reg, p1y_reg, p2x_reg, p2y_reg;
    logic [WEIGHT_W-1:0]       w_reg;
    logic [CNT_W-1:0]          cnt_reg, k_reg;
    logic [A_W-1:0]            a_reg;
    logic [PW-1:0]             pa_reg, pk_reg;
    logic [CW-1:0]             c0_reg, c2_reg;
    logic [TW-1:0]             t_reg;
    logic [C1W-1:0]            c1_reg;
    logic [DEN_W-1:0]          den_reg;
    logic signed [ACC_W-1:0]   accx_reg, accy_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [REM_W-1:0]          remx_reg, remy_reg;
    logic [QN-1:0]             shx_reg, shy_reg, qx_reg, qy_reg;
    logic                      negx_reg, negy_reg;
    logic [COORD_W-1:0]        resx_reg, resy_reg;
    logic                      err_reg;
    logic                      ovalid_reg;
    logic [IDX_W-1:0]          oidx_reg;
    logic [COORD_W-1:0]        ox_reg, oy_reg;
    logic                      oerr_reg, olast_reg;

    logic [ORDER_W-1:0]        ord_eff;
    logic [CNT_W-1:0]          cnt_eff;
    logic [ORDER_W-1:0]        nm1;
    logic [1:0]                term;
    logic                      axis_y;
    logic [CW-1:0]             coef_sel;
    logic [COORD_W-1:0]        pt_sel;
    logic signed [MUL_W-1:0]   prod;
    logic signed [ACC_W-1:0]   prod_ext, prod_sh;
    logic [ACC_W-1:0]          magx, magy;
    logic [REM_W-1:0]          trialx, trialy;
    logic                      fitx, fity;
    logic [QN:0]               qrx, qry;
    logic [COORD_W-1:0]        satx, saty;
    logic                      den_zero;

    assign ord_eff = (in_order > MAX_ORD) ? MAX_ORD : in_order;
    assign cnt_eff = (sc_reg == '0) ? CNT_W'(1) : ((sc_reg > MAX_CNT) ? MAX_CNT : sc_reg);
    assign nm1     = (ord_reg == '0) ? '0 : ord_reg - ORDER_W'(1);

    assign sts.pow_done = (step_reg == STEP_W'(nm1));
    assign sts.mac_done = (step_reg == STEP_W'(MAC_STEPS - 1));
    assign sts.div_done = (step_reg == STEP_W'(QN - 1));
    assign sts.last_k   = (k_reg == cnt_reg);
    assign sts.out_free = !ovalid_reg || out_ready;

    // Product schedule: even steps feed x, odd steps feed y. The middle
    // coefficient is split into two halves to keep the multiplier narrow.
    assign term   = step_reg[2:1];
    assign axis_y = step_reg[0];

    always_comb
    begin
        case (term)
            2'd0:    coef_sel = c0_reg;
            2'd1:    coef_sel = c2_reg;
            2'd2:    coef_sel = c1_reg[CW-1:0];
            default: coef_sel = c1_reg[C1W-1:CW];
        endcase
        case (term)
            2'd0:    pt_sel = axis_y ? p0y_reg : p0x_reg;
            2'd1:    pt_sel = axis_y ? p2y_reg : p2x_reg;
            default: pt_sel = axis_y ? p1y_reg : p1x_reg;
        endcase
    end

    assign prod     = $signed({1'b0, coef_sel}) * $signed(pt_sel);
    assign prod_ext = ACC_W'(prod);

    always_comb
    begin
        case (term)
            2'd0, 2'd1: prod_sh = prod_ext <<< ONE_SHIFT;
            2'd2:       prod_sh = prod_ext;
            default:    prod_sh = prod_ext <<< CW;
        endcase
    end

    assign magx = accx_reg[ACC_W-1] ? ACC_W'(-accx_reg) : accx_reg;
    assign magy = accy_reg[ACC_W-1] ? ACC_W'(-accy_reg) : accy_reg;

    assign trialx = {remx_reg[REM_W-2:0], shx_reg[QN-1]};
    assign trialy = {remy_reg[REM_W-2:0], shy_reg[QN-1]};
    assign fitx   = (trialx >= den_reg);
    assign fity   = (trialy >= den_reg);

    // Round half away from zero on the magnitude, then saturate.
    assign qrx = ({remx_reg, 1'b0} >= {1'b0, den_reg}) ? {1'b0, qx_reg} + 1'b1
                                                       : {1'b0, qx_reg};
    assign qry = ({remy_reg, 1'b0} >= {1'b0, den_reg}) ? {1'b0, qy_reg} + 1'b1
                                                       : {1'b0, qy_reg};
    assign den_zero = (den_reg == '0);

    always_comb
    begin
        if (negx_reg)
            satx = (qrx > (QN+1)'(NEG_MIN)) ? NEG_MIN : COORD_W'(-qrx);
        else
            satx = (qrx > (QN+1)'(POS_MAX)) ? POS_MAX : qrx[COORD_W-1:0];
        if (negy_reg)
            saty = (qry > (QN+1)'(NEG_MIN)) ? NEG_MIN : COORD_W'(-qry);
        else
            saty = (qry > (QN+1)'(POS_MAX)) ? POS_MAX : qry[COORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg     <= SAMPLE_COUNT_RESET;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en) sc_reg <= cfg_wr_data;
            if (cmd.op == OP_EMIT) ovalid_reg <= 1'b1;
            else if (out_ready) ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                ord_reg <= ord_eff;
                p0x_reg <= in_sx;
                p0y_reg <= in_sy;
                p1x_reg <= in_rx;
                p1y_reg <= in_ry;
                p2x_reg <= in_ex;
                p2y_reg <= in_ey;
                w_reg   <= in_w;
                cnt_reg <= cnt_eff;
                k_reg   <= CNT_W'(1);
            end
            OP_SETUP:
            begin
                a_reg    <= A_W'(cnt_reg - k_reg);
                pa_reg   <= PW'(1);
                pk_reg   <= PW'(1);
                step_reg <= '0;
            end
            OP_POW:
            begin
                pa_reg   <= PW'(pa_reg * a_reg);
                pk_reg   <= PW'(pk_reg * k_reg);
                step_reg <= step_reg + STEP_W'(1);
            end
            OP_COEF1:
            begin
                c0_reg <= CW'(pa_reg * a_reg);
                c2_reg <= CW'(pk_reg * k_reg);
                t_reg  <= TW'(pa_reg * k_reg);
            end
            OP_COEF2:
            begin
                t_reg <= TW'(t_reg * ord_reg);
            end
            OP_COEF3:
            begin
                c1_reg   <= (ord_reg >= ORDER_W'(2)) ? C1W'(t_reg * w_reg) : '0;
                accx_reg <= '0;
                accy_reg <= '0;
                step_reg <= '0;
            end
            OP_MAC:
            begin
                if (step_reg == '0)
                    den_reg <= ((DEN_W'(c0_reg) + DEN_W'(c2_reg)) << ONE_SHIFT)
                               + DEN_W'(c1_reg);
                if (axis_y) accy_reg <= accy_reg + prod_sh;
                else        accx_reg <= accx_reg + prod_sh;
                step_reg <= step_reg + STEP_W'(1);
            end
            OP_DIVINIT:
            begin
                negx_reg <= accx_reg[ACC_W-1];
                negy_reg <= accy_reg[ACC_W-1];
                remx_reg <= REM_W'(magx[MAG_W-1:QN]);
                remy_reg <= REM_W'(magy[MAG_W-1:QN]);
                shx_reg  <= magx[QN-1:0];
                shy_reg  <= magy[QN-1:0];
                qx_reg   <= '0;
                qy_reg   <= '0;
                step_reg <= '0;
            end
            OP_DIV:
            begin
                remx_reg <= fitx ? trialx - den_reg : trialx;
                remy_reg <= fity ? trialy - den_reg : trialy;
                qx_reg   <= {qx_reg[QN-2:0], fitx};
                qy_reg   <= {qy_reg[QN-2:0], fity};
                shx_reg  <= shx_reg << 1;
                shy_reg  <= shy_reg << 1;
                step_reg <= step_reg + STEP_W'(1);
            end
            OP_FINISH:
            begin
                if (ord_reg == '0)
                begin
                    resx_reg <= '0;
                    resy_reg <= '0;
                    err_reg  <= 1'b0;
                end
                else if (den_zero)
                begin
                    resx_reg <= negx_reg ? NEG_MIN : POS_MAX;
                    resy_reg <= negy_reg ? NEG_MIN : POS_MAX;
                    err_reg  <= 1'b1;
                end
                else
                begin
                    resx_reg <= satx;
                    resy_reg <= saty;
                    err_reg  <= 1'b0;
                end
            end
            OP_EMIT:
            begin
                oidx_reg  <= IDX_W'(k_reg - CNT_W'(1));
                ox_reg    <= resx_reg;
                oy_reg    <= resy_reg;
                oerr_reg  <= err_reg;
                olast_reg <= (k_reg == cnt_reg);
                k_reg     <= k_reg + CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = ovalid_reg;
    assign out_index = oidx_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_err   = oerr_reg;
    assign out_last  = olast_reg;

endmodule

FILE: hdl/rational_bezier_path_sampler_top.sv
// ---------------------------------------------------------------------------
// rational_bezier_path_sampler_top
// Samples a rational Bezier path at N evenly spaced parameter values.
// ---------------------------------------------------------------------------
// Each request item produces sample_count point items (0 is taken as 1 and
// counts above MAX_SAMPLES are capped), for t = k/N with k = 1..N, the last
// one marked by last_sample. Each sample passes through setup, up to three
// power steps, three coefficient steps, eight passes of the shared 26x32
// multiply-accumulate unit, a 33-step restoring division for x and y in
// parallel and rounding, and is then loaded into the output register. A
// stalled output register holds the next sample until it is free. A new
// request is taken only after the previous request's last point has been
// loaded into the output register.
// sample_count may be written only while idle.
module rational_bezier_path_sampler_top #(
    parameter int MAX_SAMPLES = rbps_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_ORDER   = rbps_pkg::DEF_MAX_ORDER
) (
    input  logic                       clk,
    input  logic                       rst_n,
    rbps_in_if.sink                    in_ch,
    rbps_out_if.source                 out_ch,
    input  logic                       cfg_wr_en,
    input  logic [rbps_pkg::CNT_W-1:0] cfg_wr_data
);
    import rbps_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rbps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rbps_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_ORDER   (MAX_ORDER)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_order    (in_ch.curve_order),
        .in_sx       (in_ch.start_x),
        .in_sy       (in_ch.start_y),
        .in_rx       (in_ch.ref_x),
        .in_ry       (in_ch.ref_y),
        .in_w        (in_ch.ref_weight),
        .in_ex       (in_ch.end_x),
        .in_ey       (in_ch.end_y),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_index   (out_ch.sample_index),
        .out_x       (out_ch.point_x),
        .out_y       (out_ch.point_y),
        .out_err     (out_ch.div_error),
        .out_last    (out_ch.last_sample)
    );

endmodule

FILE: verif/rational_bezier_path_sampler_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rational_bezier_path_sampler_top_tb
// Drives path requests under several sample counts, predicts each sampled
// curve point with exact wide integer math and compares every output item
// field by field against the oldest predicted point.
// ---------------------------------------------------------------------------
module rational_bezier_path_sampler_top_tb;
    import rbps_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int MAX_SHOWN   = 10;

    typedef struct {
        logic [ORDER_W-1:0]        order;
        logic signed [COORD_W-1:0] sx, sy, rx, ry, ex, ey;
        logic [WEIGHT_W-1:0]       w;
    } path_req_t;

    typedef struct {
        logic [IDX_W-1:0]          idx;
        logic signed [COORD_W-1:0] px, py;
        logic                      err, last;
    } curve_pt_t;

    class point_scoreboard;
        curve_pt_t          pending_pts[$];
        logic [CNT_W-1:0]   samples_reg;
        int                 mismatches;

        function new();
            samples_reg = SAMPLE_COUNT_RESET;
            mismatches  = 0;
        endfunction

        function longint unsigned upow(longint unsigned b, int e);
            longint unsigned r;
            r = 1;
            for (int i = 0; i < e; i++) r = r * b;
            return r;
        endfunction

        // Rounded, saturated quotient of one coordinate axis.
        function logic [31:0] blend_axis(longint unsigned c0, longint unsigned c1,
                                         longint unsigned c2,
                                         logic signed [31:0] p0,
                                         logic signed [31:0] p1,
                                         logic signed [31:0] p2,
                                         longint unsigned den);
            logic signed [127:0] s0, s1, s2, e0, e1, e2, num;
            logic [127:0] mag, q, r, d;
            logic neg;
            s0 = 128'(c0); s1 = 128'(c1); s2 = 128'(c2);
            e0 = 128'(p0); e1 = 128'(p1); e2 = 128'(p2);
            num = s0 * e0 + s1 * e1 + s2 * e2;
            neg = num[127];
            if (den == 0) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            mag = neg ? -num : num;
            d = 128'(den);
            q = mag / d;
            r = mag % d;
            if ((r << 1) >= d) q = q + 128'd1;
            if (neg)
            begin
                if (q > 128'h8000_0000) q = 128'h8000_0000;
                return -q[31:0];
            end
            if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
            return q[31:0];
        endfunction

        function void note_request(path_req_t rq);
            int n, cnt;
            longint unsigned a, c0, c1, c2, den;
            curve_pt_t pt;
            n = int'(rq.order);
            if (n > DEF_MAX_ORDER) n = DEF_MAX_ORDER;
            cnt = int'(samples_reg);
            if (cnt == 0) cnt = 1;
            if (cnt > DEF_MAX_SAMPLES) cnt = DEF_MAX_SAMPLES;
            for (int k = 1; k <= cnt; k++)
            begin
                pt.px = 0; pt.py = 0; pt.err = 0;
                if (n > 0)
                begin
                    a  = longint'(cnt - k);
                    c0 = upow(a, n) << ONE_SHIFT;
                    c1 = (n >= 2) ? longint'(n) * upow(a, n - 1) * k * rq.w : 0;
                    c2 = upow(longint'(k), n) << ONE_SHIFT;
                    den = c0 + c1 + c2;
                    pt.err = (den == 0);
                    pt.px = blend_axis(c0, c1, c2, rq.sx, rq.rx, rq.ex, den);
                    pt.py = blend_axis(c0, c1, c2, rq.sy, rq.ry, rq.ey, den);
                end
                pt.idx  = IDX_W'(k - 1);
                pt.last = (k == cnt);
                pending_pts.push_back(pt);
            end
        endfunction

        function void check_point(curve_pt_t got);
            curve_pt_t want;
            if (pending_pts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected point item idx=%0d x=%h y=%h", got.idx,
                             got.px, got.py);
                return;
            end
            want = pending_pts.pop_front();
            if (got.idx !== want.idx || got.px !== want.px || got.py !== want.py ||
                got.err !== want.err || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display({"point mismatch: exp idx=%0d x=%h y=%h err=%b last=%b, ",
                              "got idx=%0d x=%h y=%h err=%b last=%b"},
                             want.idx, want.px, want.py, want.err, want.last,
                             got.idx, got.px, got.py, got.err, got.last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;
    int cycles;
    int stall_mode;

    rbps_in_if  in_ch();
    rbps_out_if out_ch();

    point_scoreboard sb = new();

    rational_bezier_path_sampler_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: out_ch.ready follows one of four stall patterns, chosen anew at random.
    always @(posedge clk)
    begin
        if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 1) == 1);
            2: out_ch.ready <= ($urandom_range(0, 7) == 0);
            default: out_ch.ready <= ((cycles / 23) % 2 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        curve_pt_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.idx  = out_ch.sample_index;
            got.px   = out_ch.point_x;
            got.py   = out_ch.point_y;
            got.err  = out_ch.div_error;
            got.last = out_ch.last_sample;
            sb.check_point(got);
        end
    end

    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 0;
            3, 4: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic path_req_t pick_req();
        path_req_t rq;
        rq.order = ORDER_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                          : $urandom_range(1, 4));
        rq.sx = pick_coord(); rq.sy = pick_coord();
        rq.rx = pick_coord(); rq.ry = pick_coord();
        rq.ex = pick_coord(); rq.ey = pick_coord();
        case ($urandom_range(0, 5))
            0: rq.w = 0;
            1: rq.w = 24'hFF_FFFF;
            2: rq.w = 24'h01_0000;
            3: rq.w = WEIGHT_W'($urandom_range(0, 24'h04_0000));
            default: rq.w = WEIGHT_W'($urandom);
        endcase
        return rq;
    endfunction

    task automatic send_req(path_req_t rq);
        in_ch.curve_order <= rq.order;
        in_ch.start_x     <= rq.sx;
        in_ch.start_y     <= rq.sy;
        in_ch.ref_x       <= rq.rx;
        in_ch.ref_y       <= rq.ry;
        in_ch.ref_weight  <= rq.w;
        in_ch.end_x       <= rq.ex;
        in_ch.end_y       <= rq.ey;
        in_ch.valid       <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_request(rq);
    endtask

    // Ends a burst at random, then leaves the request line idle for a while.
    task automatic maybe_gap();
        if ($urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_pts.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_samples(logic [CNT_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.samples_reg = val;
        @(posedge clk);
    endtask

    task automatic run_phase(logic [CNT_W-1:0] val, int items);
        drain();
        write_samples(val);
        for (int i = 0; i < items; i++)
        begin
            send_req(pick_req());
            if (i == items / 2 && $urandom_range(0, 1) == 0) drain();
            else maybe_gap();
        end
    endtask

    initial
    begin
        path_req_t rq;
        cycles = 0;
        stall_mode = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_ch.valid = 1'b0;
        in_ch.curve_order = '0;
        in_ch.start_x = '0; in_ch.start_y = '0;
        in_ch.ref_x = '0;   in_ch.ref_y = '0;
        in_ch.ref_weight = '0;
        in_ch.end_x = '0;   in_ch.end_y = '0;
        out_ch.ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests at the reset sample count: every order including
        // those above the maximum, extreme points and weights.
        for (int o = 0; o < 8; o++)
        begin
            rq.order = ORDER_W'(o);
            rq.sx = 32'sh7FFF_FFFF; rq.sy = 32'sh8000_0000;
            rq.rx = 32'sh8000_0000; rq.ry = 32'sh7FFF_FFFF;
            rq.ex = 32'sh8000_0000; rq.ey = 32'sh7FFF_FFFF;
            rq.w  = (o % 2) ? 24'hFF_FFFF : 24'h00_0000;
            send_req(rq);
        end
        for (int o = 1; o <= 4; o++)
        begin
            rq.order = ORDER_W'(o);
            rq.sx = 0; rq.sy = 32'sh0001_0000;
            rq.rx = 32'sh0005_0000; rq.ry = -32'sh0003_0000;
            rq.ex = 32'sh000A_0000; rq.ey = 32'sh7FFF_FFFF;
            rq.w  = 24'h01_0000;
            send_req(rq);
            rq.w  = 24'hFF_FFFF;
            rq.rx = 32'sh7FFF_FFFF; rq.ry = 32'sh8000_0000;
            send_req(rq);
            rq.w  = 24'h00_0001;
            send_req(rq);
        end

        // Random phases: the extremes of the sample count and 2, then random counts and finally the reset count.
        run_phase(7'd1, 60);
        run_phase(7'd0, 20);
        run_phase(7'd64, 8);
        run_phase(7'd127, 6);
        run_phase(7'd2, 60);
        for (int p = 0; p < 6; p++) run_phase(CNT_W'($urandom_range(3, 16)), 30);
        run_phase(SAMPLE_COUNT_RESET, 10);

        drain();
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_pts.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
hdl/rbps_pkg.sv
hdl/rbps_in_if.sv
hdl/rbps_out_if.sv
hdl/rbps_ctrl.sv
hdl/rbps_dp.sv
hdl/rational_bezier_path_sampler_top.sv
verif/rational_bezier_path_sampler_top_tb.sv
